// ===== rtl/cds_pkg.sv =====
package cds_pkg;

  // Field widths
  localparam int unsigned YearW   = 16;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned StepW   = 12;
  localparam int unsigned PackedW = 30;
  localparam int unsigned YmodW   = 9;
  localparam int unsigned QuotW   = 8;

  // Item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindStep = 1'b1;

  // Month codes with special handling
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // Year modulo 400 tracking; year 65535 sits at 335 in the cycle
  localparam int unsigned       GregCycle = 400;
  localparam logic [YmodW-1:0]  YmodLast  = 9'd399;
  localparam logic [YmodW-1:0]  YmodTop   = 9'd335;
  localparam logic [YmodW-1:0]  YmodC1    = 9'd100;
  localparam logic [YmodW-1:0]  YmodC2    = 9'd200;
  localparam logic [YmodW-1:0]  YmodC3    = 9'd300;

  // floor(y / 400) = (y * RecipMul) >> RecipShift, exact for 16-bit y
  localparam int unsigned RecipShift = 25;
  localparam logic [16:0] RecipMul   = 17'd83887;

  // Packed date scaling
  localparam logic [PackedW-1:0] YearScale  = 30'd10000;
  localparam logic [PackedW-1:0] MonthScale = 30'd100;

  typedef struct packed {
    logic                    kind;
    logic [YearW-1:0]        load_year;
    logic [MonthW-1:0]       load_month;
    logic [DayW-1:0]         load_day;
    logic signed [StepW-1:0] step_days;
  } in_item_t;

  typedef struct packed {
    logic [YearW-1:0]   out_year;
    logic [MonthW-1:0]  out_month;
    logic [DayW-1:0]    out_day;
    logic [PackedW-1:0] packed_date;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the loaded date
    logic start;  // take the step count and direction
    logic step;   // move the date by one day
    logic emit;   // capture the date into the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_load;    // incoming item is a load
    logic step_zero;  // incoming step count is zero
    logic cnt_last;   // one day left to move
  } status_t;

  // Days in a month; out-of-range months count 30 days
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cds_chan_if.sv =====
interface cds_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/calendar_date_stepper.sv =====
// Channel   Dir  Payload                                        Handshake
// in_i      in   kind, load_year, load_month, load_day, step    valid/ready
// out_o     out  out_year, out_month, out_day, packed_date      valid/ready
//
// A load or a zero step moves no days; a step of n days moves the date
// one day per cycle in the datapath, with n capped at MAX_STEP.
// One item is worked at a time; the next is taken as soon as the previous
// result is in the output register, even while that result is still waiting.
// A stalled output holds the result register and blocks the next capture.
// Reset gives year 0, month 1, day 1 and an empty output register.
module calendar_date_stepper #(
  parameter int MAX_STEP = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cds_chan_if.sink   in_i,
  cds_chan_if.source out_o
);
  import cds_pkg::*;

  cmd_t      cmd;
  status_t   st;
  out_item_t out_data;

  cds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  cds_dpath #(
    .MAX_STEP (MAX_STEP)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_data_o (out_data)
  );

  assign out_o.data = out_data;

endmodule

// ===== rtl/cds_ctrl.sv =====
module cds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cds_pkg::status_t st_i,
  output cds_pkg::cmd_t    cmd_o
);
  import cds_pkg::*;

  localparam logic SIdle = 1'b0;
  localparam logic SStep = 1'b1;

  logic state_q, state_d;
  logic pend_q, pend_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;
  logic accept;
  logic step_done;

  // Result slot and handshake
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == SIdle) && (!pend_q || slot_free);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Commands
  assign cmd_o.load  = accept && st_i.is_load;
  assign cmd_o.start = accept && !st_i.is_load && !st_i.step_zero;
  assign cmd_o.step  = (state_q == SStep);
  assign cmd_o.emit  = (state_q == SIdle) && pend_q && slot_free;
  assign step_done   = cmd_o.step && st_i.cnt_last;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (cmd_o.start) state_d = SStep;
      end
      SStep: begin
        if (st_i.cnt_last) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Pending result and output valid
  always_comb begin
    pend_d = pend_q;
    if (cmd_o.emit) pend_d = 1'b0;
    if ((accept && (st_i.is_load || st_i.step_zero)) || step_done) pend_d = 1'b1;

    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result is never captured over one that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result captured over a waiting item");

  // No item is taken while days are still being moved
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SStep) |-> !in_ready_o)
    else $error("item accepted during a step run");

  // The last day of a run leaves a result pending
  a_done_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_done |=> (pend_q && state_q == SIdle))
    else $error("step run ended without a pending result");

endmodule

// ===== rtl/cds_dpath.sv =====
module cds_dpath #(
  parameter int MAX_STEP = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cds_pkg::in_item_t  in_data_i,
  input  cds_pkg::cmd_t      cmd_i,
  output cds_pkg::status_t   st_o,
  output cds_pkg::out_item_t out_data_o
);
  import cds_pkg::*;

  // Largest count that a 12-bit step can ask for is 2048
  localparam int CapMax = (MAX_STEP < 2048) ? MAX_STEP : 2048;
  localparam int CntW   = $clog2(CapMax + 1);

  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [YmodW-1:0]  ymod_q, ymod_d;
  logic [QuotW-1:0]  quot_q;
  logic              mod_pend_q;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q;
  out_item_t         out_q;

  logic [StepW-1:0]  raw;
  logic [StepW-1:0]  mag;
  logic [CntW-1:0]   cnt_start;
  logic [32:0]       recip_prod;
  logic [YearW-1:0]  ymod_wide;
  logic              leap;
  logic [MonthW-1:0] month_back;
  logic [DayW:0]     day_inc;
  logic [PackedW-1:0] packed_sum;

  // Step magnitude, saturated
  assign raw = in_data_i.step_days;
  assign mag = raw[StepW-1] ? StepW'(12'd0 - raw) : raw;
  always_comb begin
    if (32'(mag) > 32'(MAX_STEP)) begin
      cnt_start = CntW'(MAX_STEP);
    end else begin
      cnt_start = CntW'(mag);
    end
  end

  assign st_o.is_load   = (in_data_i.kind == KindLoad);
  assign st_o.step_zero = (raw == '0);
  assign st_o.cnt_last  = (cnt_q == CntW'(1));

  // Year modulo 400 after a load: quotient first, remainder in the cycle after
  assign recip_prod = 33'(in_data_i.load_year) * 33'(RecipMul);
  assign ymod_wide  = year_q - 16'(16'(quot_q) * 16'(GregCycle));

  // Leap year from the position in the 400-year cycle
  assign leap = (ymod_q[1:0] == 2'b00) && (ymod_q != YmodC1) &&
                (ymod_q != YmodC2) && (ymod_q != YmodC3);

  assign day_inc    = {1'b0, day_q} + 6'd1;
  assign month_back = (month_q == MonthJan) ? MonthDec : MonthW'(month_q - 4'd1);

  // Load a date, or move it one day forward or backward
  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    ymod_d  = ymod_q;
    if (mod_pend_q) ymod_d = ymod_wide[YmodW-1:0];
    if (cmd_i.load) begin
      year_d  = in_data_i.load_year;
      month_d = in_data_i.load_month;
      day_d   = in_data_i.load_day;
    end else if (cmd_i.step) begin
      if (!neg_q) begin
        if (day_inc <= {1'b0, month_len(month_q, leap)}) begin
          day_d = day_inc[DayW-1:0];
        end else begin
          day_d = 5'd1;
          if (month_q == MonthDec) begin
            month_d = MonthJan;
            year_d  = YearW'(year_q + 16'd1);
            if (year_q == '1)             ymod_d = '0;
            else if (ymod_q == YmodLast)  ymod_d = '0;
            else                          ymod_d = YmodW'(ymod_q + 9'd1);
          end else begin
            month_d = MonthW'(month_q + 4'd1);
          end
        end
      end else begin
        if (day_q > 5'd1) begin
          day_d = DayW'(day_q - 5'd1);
        end else begin
          month_d = month_back;
          // Only month 2 depends on the year, and it is reached from March
          day_d   = month_len(month_back, leap);
          if (month_q == MonthJan) begin
            year_d = YearW'(year_q - 16'd1);
            if (year_q == '0)        ymod_d = YmodTop;
            else if (ymod_q == '0)   ymod_d = YmodLast;
            else                     ymod_d = YmodW'(ymod_q - 9'd1);
          end
        end
      end
    end
  end

  // Date state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q     <= '0;
      month_q    <= MonthJan;
      day_q      <= 5'd1;
      ymod_q     <= '0;
      mod_pend_q <= 1'b0;
    end else begin
      year_q     <= year_d;
      month_q    <= month_d;
      day_q      <= day_d;
      ymod_q     <= ymod_d;
      mod_pend_q <= cmd_i.load;
    end
  end

  // Quotient, day counter and direction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) quot_q <= recip_prod[RecipShift +: QuotW];
    if (cmd_i.start) begin
      cnt_q <= cnt_start;
      neg_q <= raw[StepW-1];
    end else if (cmd_i.step) begin
      cnt_q <= CntW'(cnt_q - CntW'(1));
    end
  end

  // Result register
  assign packed_sum = 30'(year_q) * YearScale + 30'(month_q) * MonthScale + 30'(day_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_year    <= year_q;
      out_q.out_month   <= month_q;
      out_q.out_day     <= day_q;
      out_q.packed_date <= packed_sum;
    end
  end

  assign out_data_o = out_q;

  // The cycle position always stays inside the 400-year cycle
  a_ymod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ymod_q <= YmodLast)
    else $error("year cycle position out of range");

  // A started run always has days to move
  a_start_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> (cnt_q != '0))
    else $error("step run started with a zero count");

endmodule

// ===== tb/sv/tb_calendar_date_stepper.sv =====
module tb_calendar_date_stepper;
  import cds_pkg::*;

  localparam int StepCap    = 1024;
  localparam int HoldAt     = 150;   // result count at which the sink holds off
  localparam int HoldCycles = 300;

  logic clk_i;
  logic rst_ni;

  cds_chan_if #(.T(in_item_t))  in_if ();
  cds_chan_if #(.T(out_item_t)) out_if ();

  calendar_date_stepper #(
    .MAX_STEP(StepCap)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Tracks the date the block should hold and the dates it still owes
  class date_tracker;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    out_item_t         expected_dates[$];
    int unsigned       failures;

    function new();
      year     = '0;
      month    = MonthJan;
      day      = 5'd1;
      failures = 0;
    endfunction

    static function bit is_leap_year(logic [YearW-1:0] y);
      int unsigned yy;
      yy = y;
      if (yy % 4 != 0) return 1'b0;
      if (yy % 100 != 0) return 1'b1;
      return (yy % 400) == 0;
    endfunction

    // Months outside 1..12 count 30 days
    static function logic [DayW-1:0] days_in_month(logic [YearW-1:0] y,
                                                   logic [MonthW-1:0] m);
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
        4'd2:    return is_leap_year(y) ? 5'd29 : 5'd28;
        default: return 5'd30;
      endcase
    endfunction

    function void advance_one_day();
      if (int'(day) + 1 <= int'(days_in_month(year, month))) begin
        day = day + 5'd1;
        return;
      end
      day = 5'd1;
      if (month == MonthDec) begin
        month = MonthJan;
        year  = year + 16'd1;
      end else begin
        month = month + 4'd1;   // 15 wraps to 0
      end
    endfunction

    function void retreat_one_day();
      if (day > 5'd1) begin
        day = day - 5'd1;
        return;
      end
      // day 0 borrows just like day 1
      if (month == MonthJan) begin
        month = MonthDec;
        year  = year - 16'd1;
      end else begin
        month = month - 4'd1;   // 0 wraps to 15, year untouched
      end
      day = days_in_month(year, month);
    endfunction

    function void note_item(in_item_t it);
      out_item_t   res;
      int          count;
      int          mag;
      logic [31:0] pk;
      if (it.kind == KindLoad) begin
        year  = it.load_year;
        month = it.load_month;
        day   = it.load_day;
      end else begin
        count = int'(it.step_days);
        mag   = (count < 0) ? -count : count;
        if (mag > StepCap) mag = StepCap;
        repeat (mag) begin
          if (count < 0) retreat_one_day();
          else advance_one_day();
        end
      end
      pk = 32'(year) * 32'd10000 + 32'(month) * 32'd100 + 32'(day);
      res.out_year    = year;
      res.out_month   = month;
      res.out_day     = day;
      res.packed_date = pk[PackedW-1:0];
      expected_dates.push_back(res);
    endfunction

    function void check_date(out_item_t got);
      out_item_t want;
      if (expected_dates.size() == 0) begin
        $error("unexpected result: %0d-%0d-%0d", got.out_year, got.out_month,
               got.out_day);
        failures++;
        return;
      end
      want = expected_dates.pop_front();
      if (got.out_year !== want.out_year) begin
        $error("out_year: expected %0d, got %0d", want.out_year, got.out_year);
        failures++;
      end
      if (got.out_month !== want.out_month) begin
        $error("out_month: expected %0d, got %0d", want.out_month, got.out_month);
        failures++;
      end
      if (got.out_day !== want.out_day) begin
        $error("out_day: expected %0d, got %0d", want.out_day, got.out_day);
        failures++;
      end
      if (got.packed_date !== want.packed_date) begin
        $error("packed_date: expected %0d, got %0d", want.packed_date,
               got.packed_date);
        failures++;
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  date_tracker tracker = new();
  bit          send_steady;
  bit          recv_steady;
  int          dates_seen;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Unused fields get random bits so every input bit toggles
  function automatic in_item_t noise_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t load_of(int unsigned y, int unsigned m, int unsigned d);
    in_item_t it;
    it            = noise_item();
    it.kind       = KindLoad;
    it.load_year  = y[YearW-1:0];
    it.load_month = m[MonthW-1:0];
    it.load_day   = d[DayW-1:0];
    return it;
  endfunction

  function automatic in_item_t step_of(int n);
    in_item_t it;
    it           = noise_item();
    it.kind      = KindStep;
    it.step_days = n[StepW-1:0];
    return it;
  endfunction

  // Offer one item after a random gap; valid stays high when there is no gap
  task automatic send_item(input in_item_t it);
    int gap;
    if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_item(it);
  endtask

  // Stop offering and wait for every owed date
  task automatic drain_dates();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t random_load();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 7))
          0: y = 0;
          1: y = 1;
          2: y = 65535;
          3: y = 65534;
          4: y = 1900;
          5: y = 2000;
          6: y = 2100;
          default: y = 2400;
        endcase
      end
      1: y = $urandom_range(1895, 2105);
      default: y = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      // out-of-range month or day, stored as is
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end else begin
      m = $urandom_range(1, 12);
      d = $urandom_range(1, date_tracker::days_in_month(y[YearW-1:0], m[MonthW-1:0]));
      if ($urandom_range(0, 3) == 0) d = date_tracker::days_in_month(y[YearW-1:0],
                                                                     m[MonthW-1:0]);
    end
    return load_of(y, m, d);
  endfunction

  function automatic int random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 0;
    if (r < 40) return $urandom_range(0, 1) ? 1 : -1;
    if (r < 70) return int'($urandom_range(0, 6)) - 3;
    if (r < 92) return int'($urandom_range(0, 120)) - 60;
    if (r < 96) return int'($urandom_range(0, 2048)) - 1024;
    return int'($urandom_range(0, 4095)) - 2048;   // beyond the cap too
  endfunction

  // Sender
  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    rst_ni       <= 1'b0;
    send_steady  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset date, year wrap, leap rules, odd loads, saturation
    send_item(step_of(0));
    send_item(step_of(-1));
    send_item(step_of(1));
    send_item(load_of(2024, 2, 28));
    send_item(step_of(1));
    send_item(step_of(1));
    send_item(load_of(1900, 2, 28));
    send_item(step_of(1));
    send_item(load_of(2000, 3, 1));
    send_item(step_of(-1));
    send_item(load_of(65535, 15, 31));
    send_item(step_of(1));
    send_item(step_of(-1));
    send_item(load_of(2023, 0, 0));
    send_item(step_of(-1));
    send_item(load_of(2023, 4, 31));
    send_item(step_of(1));
    send_item(load_of(2023, 2, 31));
    send_item(step_of(-3));
    send_item(load_of(2023, 6, 0));
    send_item(step_of(1));
    send_item(step_of(2047));
    send_item(step_of(-2048));
    send_item(step_of(1024));
    send_item(step_of(-1025));
    send_item(load_of(2023, 13, 15));
    send_item(step_of(20));
    drain_dates();
    @(posedge clk_i);

    // Random: mostly short steps with the odd load
    for (int i = 0; i < 425; i++) begin
      if (i == 200) begin
        drain_dates();
        @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 15) send_item(random_load());
      else send_item(step_of(random_step()));
    end
    drain_dates();
    repeat (50) @(posedge clk_i);

    if (tracker.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off
  initial begin
    int stall;
    recv_steady  = 1'b0;
    dates_seen   = 0;
    out_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_steady = !recv_steady;
      stall = recv_steady ? 0 : $urandom_range(0, 19);
      if (dates_seen == HoldAt) stall = HoldCycles;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      tracker.check_date(out_if.data);
      dates_seen++;
    end
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cds_pkg.sv
rtl/cds_chan_if.sv
rtl/cds_ctrl.sv
rtl/cds_dpath.sv
rtl/calendar_date_stepper.sv
tb/sv/tb_calendar_date_stepper.sv
